// ===== src/dnle_pkg.sv =====
// Shared types and constants for the dotted name label encoder.
package dnle_pkg;

   // Width of one name character and of one encoded byte.
   localparam int unsigned BYTE_W = 8;

   // The character that separates labels.
   localparam logic [BYTE_W-1:0] SEP_CHAR = 8'd46;

   // Controls that the sequencer hands to every cell of the label chain.
   typedef struct packed {
      logic load;    // Capture the incoming character.
      logic shift;   // Take the neighbor's character.
   } cell_ctl_type;

endpackage

// ===== src/dnle_if.sv =====
// Valid/ready channel interfaces for the name characters and the encoded bytes.
interface dnle_req_if;
   import dnle_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] name_char;
   logic              final_char;

   modport source (output valid, output name_char, output final_char, input ready);
   modport sink (input valid, input name_char, input final_char, output ready);
endinterface

interface dnle_rsp_if;
   import dnle_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              is_length;
   logic              label_overflow;
   logic              end_of_name;

   modport source (output valid, output out_byte, output is_length,
                   output label_overflow, output end_of_name, input ready);
   modport sink (input valid, input out_byte, input is_length,
                 input label_overflow, input end_of_name, output ready);
endinterface

// ===== src/dnle_cell.sv =====
// One cell of the label chain: holds one character and passes it toward the head.
module dnle_cell (
   input  logic                          clock,
   input  dnle_pkg::cell_ctl_type        ctl,
   input  logic [dnle_pkg::BYTE_W-1:0]   load_data,
   input  logic [dnle_pkg::BYTE_W-1:0]   next_data,
   output logic [dnle_pkg::BYTE_W-1:0]   cell_data
);
   import dnle_pkg::*;

   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] data_in;

   // A load writes a new character; a shift takes the neighbor's one.
   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;

endmodule

// ===== src/dotted_name_label_encoder.sv =====
// Top level of the dotted name label encoder: sequencer, counters and the label chain.
//
// The block takes a dotted domain name one character per word and returns its
// length-prefixed label encoding one byte per word. A plain character is stored
// and produces nothing. A dot or the last character of the name flushes the
// held label: one length byte, then the characters in order, one word per
// cycle while the result side takes them, and the input side stays busy until
// the flush is done; a final dot adds the zero length of the empty label
// behind it. The characters sit in a row of MAX_LABEL cells; a flush reads the
// head cell and shifts the row by one for each character sent. Characters past
// MAX_LABEL are dropped and the length byte then carries label_overflow. No
// root zero is appended after the name.
module dotted_name_label_encoder #(
   parameter int unsigned MAX_LABEL = 62
) (
   input  logic        clock,
   input  logic        reset,
   dnle_req_if.sink    req_chan,
   dnle_rsp_if.source  rsp_chan
);
   import dnle_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_LABEL + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEN,
      ST_CHARS,
      ST_ZERO
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              ovf_ff;
   logic              zero_tail_ff;
   logic              eon_pend_ff;
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_len_ff;
   logic              rsp_ovf_ff;
   logic              rsp_eon_ff;

   logic              req_accept;
   logic              is_sep;
   logic              slot_free;
   logic              load_rsp;
   logic              store_char;
   logic              shift_chain;
   logic [BYTE_W-1:0] cell_data [MAX_LABEL];
   logic [BYTE_W-1:0] count_byte;

   // Input handshake and decode of the incoming word.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign is_sep         = (req_chan.name_char == SEP_CHAR);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign load_rsp       = slot_free && (state_ff != ST_IDLE);
   assign store_char     = req_accept && !is_sep && (count_ff < CNT_W'(MAX_LABEL));
   assign shift_chain    = (state_ff == ST_CHARS) && slot_free;
   assign count_byte     = {{(BYTE_W-CNT_W){1'b0}}, count_ff};

   // Row of label cells; the head cell is the next character to send.
   for (genvar i = 0; i < MAX_LABEL; i++) begin : g_cell
      cell_ctl_type      ctl;
      logic [BYTE_W-1:0] next_data;

      assign ctl.load  = store_char && (count_ff == CNT_W'(i));
      assign ctl.shift = shift_chain;
      if (i == MAX_LABEL - 1) begin : g_tail
         assign next_data = cell_data[i];
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end

      dnle_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_data (req_chan.name_char),
         .next_data (next_data),
         .cell_data (cell_data[i])
      );
   end

   // Sequencer with the counters and the registered result word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         zero_tail_ff <= 1'b0;
         eon_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && !load_rsp) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (is_sep) begin
                     zero_tail_ff <= req_chan.final_char;
                     eon_pend_ff  <= 1'b0;
                     state_ff     <= ST_LEN;
                  end else begin
                     if (store_char) begin
                        count_ff <= count_ff + 1'b1;
                     end else begin
                        ovf_ff <= 1'b1;
                     end
                     if (req_chan.final_char) begin
                        zero_tail_ff <= 1'b0;
                        eon_pend_ff  <= 1'b1;
                        state_ff     <= ST_LEN;
                     end
                  end
               end
            end
            ST_LEN: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_byte_ff  <= count_byte;
                  rsp_len_ff   <= 1'b1;
                  rsp_ovf_ff   <= ovf_ff;
                  rsp_eon_ff   <= eon_pend_ff && (count_ff == '0);
                  ovf_ff       <= 1'b0;
                  if (count_ff != '0) begin
                     state_ff <= ST_CHARS;
                  end else if (zero_tail_ff) begin
                     state_ff <= ST_ZERO;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_CHARS: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_byte_ff  <= cell_data[0];
                  rsp_len_ff   <= 1'b0;
                  rsp_ovf_ff   <= 1'b0;
                  rsp_eon_ff   <= eon_pend_ff && (count_ff == CNT_W'(1));
                  count_ff     <= count_ff - 1'b1;
                  if (count_ff == CNT_W'(1)) begin
                     state_ff <= zero_tail_ff ? ST_ZERO : ST_IDLE;
                  end
               end
            end
            ST_ZERO: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_byte_ff  <= '0;
                  rsp_len_ff   <= 1'b1;
                  rsp_ovf_ff   <= 1'b0;
                  rsp_eon_ff   <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_byte       = rsp_byte_ff;
   assign rsp_chan.is_length      = rsp_len_ff;
   assign rsp_chan.label_overflow = rsp_ovf_ff;
   assign rsp_chan.end_of_name    = rsp_eon_ff;

endmodule

// ===== src/dnle_checker.sv =====
// Port-level checks for the dotted name label encoder and their bind.
module dnle_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [dnle_pkg::BYTE_W-1:0] req_name_char,
   input logic                        req_final_char,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [dnle_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic                        rsp_is_length,
   input logic                        rsp_label_overflow,
   input logic                        rsp_end_of_name
);
   import dnle_pkg::*;

   logic req_accept;
   logic flush_word;

   assign req_accept = req_valid && req_ready;
   assign flush_word = req_final_char || (req_name_char == SEP_CHAR);

   // A stalled result word holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_is_length) && $stable(rsp_label_overflow)
         && $stable(rsp_end_of_name))
      else $error("Stalled result word changed.");

   // A dot or a last character starts a flush, so input stops for a while.
   a_flush_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept && flush_word |=> !req_ready)
      else $error("Input taken during a label flush.");

   // A plain character is only stored, so input stays open.
   a_store_open: assert property (@(posedge clock) disable iff (reset)
      req_accept && !flush_word |=> req_ready)
      else $error("Input blocked after storing a character.");

   // Overflow rides only on a nonzero length byte.
   a_ovf_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_label_overflow |-> rsp_is_length && (rsp_out_byte != '0))
      else $error("Overflow flag on a character or zero length byte.");

endmodule

bind dotted_name_label_encoder dnle_checker u_dnle_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_name_char      (req_chan.name_char),
   .req_final_char     (req_chan.final_char),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_out_byte       (rsp_chan.out_byte),
   .rsp_is_length      (rsp_chan.is_length),
   .rsp_label_overflow (rsp_chan.label_overflow),
   .rsp_end_of_name    (rsp_chan.end_of_name)
);
